>>> rtl/kfsp_pkg.sv
// Shared constants, types and codes for the kth free slot placement block.
package kfsp_pkg;

    // Store sizing
    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int NODE_W      = IDX_W + 1;
    localparam int TREE_NODES  = 2 * MAX_ENTRIES;
    localparam int LVL_W       = $clog2(IDX_W + 1);

    // Field widths of the stream items
    localparam int OP_W     = 2;
    localparam int POS_W    = 10;
    localparam int VAL_W    = 32;
    localparam int SLOT_W   = 10;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int SCMP_W   = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;
    localparam int S_TDATA_W = ((POS_W + VAL_W + SLOT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VAL_W + STAT_W + 7) / 8) * 8;

    // Operation codes
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_LOAD   = 2'd0;
    localparam op_t OP_FINISH = 2'd1;
    localparam op_t OP_READ   = 2'd2;

    // Status codes
    typedef logic [STAT_W-1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_POS   = 2'd2;
    localparam status_t STATUS_RANGE = 2'd3;

    // One queued insertion
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } query_t;

    // Placement sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_QRD,
        ST_QLD,
        ST_DESC,
        ST_LEAF
    } state_t;

endpackage

>>> rtl/kth_free_slot_placement.sv
// Top level: insertion queue, free-count tree placement and slot readout.
//
// Usage
//   Input transactions arrive on the s_ channel; s_tuser carries the operation
//   (load insertion, finish and place, read slot). Every input transaction
//   yields exactly one result transaction on the m_ channel, in order.
//   Loads and reads: one transaction per cycle unless the output is held; the
//   result passes the slot memory read register, then the output register.
//   Finish: the block stops taking input while it places the queue. It first
//   sweeps the free-count tree memory one node a cycle, then places the
//   insertions last to first, each by a queue memory read, a load step, one
//   descent step per tree level on the single read port of the tree memory
//   and the leaf write. Its result follows the last placement. A finish on an
//   empty queue answers like a load.
//   Reset (aresetn low, synchronous) empties the queue and drops any pending
//   result; slot and tree memories keep whatever they held.
//   When m_tready stays low the result waits in the output register while one
//   more item is taken into the stage behind it; then s_tready drops.
module kth_free_slot_placement
    import kfsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [9:0] insert_pos, [41:10] insert_value, [51:42] slot_index, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] read_value, [33:32] status, rest zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Memories
    query_t            query_store [MAX_ENTRIES];
    logic [CNT_W-1:0]  tree_mem    [TREE_NODES];
    logic [VAL_W-1:0]  slot_mem    [MAX_ENTRIES];

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  q_count_reg;
    logic              p1_valid_reg;
    logic              m_valid_reg;

    // Working registers
    logic [IDX_W-1:0]  q_idx_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [IDX_W-1:0]  init_idx_reg;
    logic [NODE_W-1:0] cur_node_reg;
    logic [CNT_W-1:0]  cur_cnt_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              p1_read_reg;
    status_t           p1_status_reg;
    logic [VAL_W-1:0]  rd_reg;
    query_t            q_rdata_reg;
    logic [CNT_W-1:0]  tree_rdata_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // Field unpacking
    op_t               in_op;
    logic [POS_W-1:0]  in_pos;
    logic [VAL_W-1:0]  in_val;
    logic [SLOT_W-1:0] in_slot;

    assign in_op   = s_tuser;
    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_val  = s_tdata[POS_W+VAL_W-1:POS_W];
    assign in_slot = s_tdata[POS_W+VAL_W+SLOT_W-1:POS_W+VAL_W];

    // Handshake
    logic p1_move, s_acc;

    assign p1_move  = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) && (!p1_valid_reg || p1_move);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Item decode and status
    status_t acc_status;
    logic    acc_read_ok, load_ok, fin_start, fin_done;

    always_comb begin
        acc_status  = STATUS_OK;
        acc_read_ok = 1'b0;
        case (in_op)
            OP_LOAD: begin
                if (q_count_reg >= CNT_W'(MAX_ENTRIES))
                    acc_status = STATUS_FULL;
                else if (CMP_W'(in_pos) > CMP_W'(q_count_reg))
                    acc_status = STATUS_POS;
            end
            OP_READ: begin
                if (SCMP_W'(in_slot) >= SCMP_W'(q_count_reg))
                    acc_status = STATUS_RANGE;
                else
                    acc_read_ok = 1'b1;
            end
            default: ;
        endcase
    end

    assign load_ok   = s_acc && (in_op == OP_LOAD) && (acc_status == STATUS_OK);
    assign fin_start = s_acc && (in_op == OP_FINISH) && (q_count_reg != '0);
    assign fin_done  = (state_reg == ST_LEAF) && (q_idx_reg == '0);

    // Tree sweep: node value is min(span, free slots from its low edge on)
    logic [LVL_W-1:0]  init_shift;
    logic [NODE_W-1:0] init_node;
    logic [CNT_W-1:0]  init_lo, init_span, init_rem, init_cnt;
    logic [IDX_W-1:0]  init_mask;
    logic              init_last;

    always_comb begin
        init_shift = LVL_W'(IDX_W) - lvl_reg;
        init_node  = (NODE_W'(1) << lvl_reg) | NODE_W'(init_idx_reg);
        init_lo    = CNT_W'(init_idx_reg) << init_shift;
        init_span  = CNT_W'(1) << init_shift;
        init_rem   = q_count_reg - init_lo;
        if (q_count_reg <= init_lo)
            init_cnt = '0;
        else if (init_rem < init_span)
            init_cnt = init_rem;
        else
            init_cnt = init_span;
        init_mask  = IDX_W'((NODE_W'(1) << lvl_reg) - NODE_W'(1));
        init_last  = (init_idx_reg == init_mask) && (lvl_reg == LVL_W'(IDX_W));
    end

    // Descent step: left child count decides the branch
    logic              go_left, nxt_leaf;
    logic [NODE_W-1:0] nxt_node;
    logic [CNT_W-1:0]  nxt_cnt, nxt_k;

    always_comb begin
        go_left  = k_reg <= tree_rdata_reg;
        nxt_node = {cur_node_reg[NODE_W-2:0], ~go_left};
        nxt_cnt  = go_left ? tree_rdata_reg : cur_cnt_reg - tree_rdata_reg;
        nxt_k    = go_left ? k_reg : k_reg - tree_rdata_reg;
        nxt_leaf = nxt_node[IDX_W];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (fin_start) state_next = ST_INIT;
            ST_INIT: if (init_last) state_next = ST_QRD;
            ST_QRD:  state_next = ST_QLD;
            ST_QLD:  state_next = ST_DESC;
            ST_DESC: if (nxt_leaf) state_next = ST_LEAF;
            ST_LEAF: state_next = fin_done ? ST_IDLE : ST_QRD;
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory controls of the sequencer
    logic              tree_re, tree_we, slot_we, q_re;
    logic [NODE_W-1:0] tree_raddr, tree_waddr;
    logic [CNT_W-1:0]  tree_wdata;

    always_comb begin
        tree_re    = 1'b0;
        tree_raddr = NODE_W'(2);
        tree_we    = 1'b0;
        tree_waddr = cur_node_reg;
        tree_wdata = cur_cnt_reg - CNT_W'(1);
        slot_we    = 1'b0;
        q_re       = 1'b0;
        case (state_reg)
            ST_INIT: begin
                tree_we    = 1'b1;
                tree_waddr = init_node;
                tree_wdata = init_cnt;
            end
            ST_QRD: q_re = 1'b1;
            ST_QLD: tree_re = 1'b1;
            ST_DESC: begin
                tree_we    = 1'b1;
                tree_re    = !nxt_leaf;
                tree_raddr = {nxt_node[NODE_W-2:0], 1'b0};
            end
            ST_LEAF: begin
                tree_we = 1'b1;
                slot_we = 1'b1;
            end
            default: ;
        endcase
    end

    // Queue memory: append on accepted load, read during placement
    always_ff @(posedge aclk) begin
        if (load_ok)
            query_store[q_count_reg[IDX_W-1:0]] <= '{pos: in_pos, value: in_val};
        if (q_re)
            q_rdata_reg <= query_store[q_idx_reg];
    end

    // Tree memory; a read never hits the node written in the same cycle
    always_ff @(posedge aclk) begin
        if (tree_we)
            tree_mem[tree_waddr] <= tree_wdata;
        if (tree_re)
            tree_rdata_reg <= tree_mem[tree_raddr];
    end

    // Slot memory: written at the leaf, read on every accepted item
    always_ff @(posedge aclk) begin
        if (slot_we)
            slot_mem[cur_node_reg[IDX_W-1:0]] <= val_reg;
        if (s_acc)
            rd_reg <= slot_mem[IDX_W'(in_slot)];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            q_count_reg  <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_ok)
                q_count_reg <= q_count_reg + CNT_W'(1);
            if ((s_acc && !fin_start) || fin_done)
                p1_valid_reg <= 1'b1;
            else if (p1_move)
                p1_valid_reg <= 1'b0;
            if (p1_move)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Sequencer working registers
    always_ff @(posedge aclk) begin
        if (fin_start) begin
            lvl_reg      <= LVL_W'(1);
            init_idx_reg <= '0;
            q_idx_reg    <= IDX_W'(q_count_reg - CNT_W'(1));
        end
        if (state_reg == ST_INIT) begin
            if (init_idx_reg == init_mask) begin
                init_idx_reg <= '0;
                lvl_reg      <= lvl_reg + LVL_W'(1);
            end else begin
                init_idx_reg <= init_idx_reg + IDX_W'(1);
            end
        end
        // Root holds one free slot per insertion still to place
        if (state_reg == ST_QLD) begin
            k_reg        <= CNT_W'(q_rdata_reg.pos) + CNT_W'(1);
            val_reg      <= q_rdata_reg.value;
            cur_node_reg <= NODE_W'(1);
            cur_cnt_reg  <= CNT_W'(q_idx_reg) + CNT_W'(1);
        end
        if (state_reg == ST_DESC) begin
            cur_node_reg <= nxt_node;
            cur_cnt_reg  <= nxt_cnt;
            k_reg        <= nxt_k;
        end
        if ((state_reg == ST_LEAF) && !fin_done)
            q_idx_reg <= q_idx_reg - IDX_W'(1);
    end

    // Result stage and output register
    always_ff @(posedge aclk) begin
        if (s_acc && !fin_start) begin
            p1_read_reg   <= acc_read_ok;
            p1_status_reg <= acc_status;
        end else if (fin_done) begin
            p1_read_reg   <= 1'b0;
            p1_status_reg <= STATUS_OK;
        end
        if (p1_move)
            m_data_reg <= M_TDATA_W'({p1_status_reg, (p1_read_reg ? rd_reg : '0)});
    end

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("queue count beyond store size");

    a_desc_k: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DESC) |-> (k_reg != '0) && (k_reg <= cur_cnt_reg))
        else $error("descent rank outside free count of node");

    a_leaf_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEAF) |-> cur_node_reg[IDX_W] && (cur_cnt_reg == CNT_W'(1))
            && (k_reg == CNT_W'(1)))
        else $error("placement reached a leaf that is not free");

    a_fin_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_done |=> p1_valid_reg)
        else $error("finish produced no result");

endmodule
